// ===== rtl/core/tfps_pkg.sv =====
package tfps_pkg;

    localparam int unsigned FreqW = 26;
    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgW  = 32;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_FREQ_A   = 2'd0;
    localparam logic [1:0] REG_FREQ_B   = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    // sequencer mode codes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_WAIT = 2'd2;

    localparam logic [2:0] TARGET_LARGE = 3'd4;
    localparam logic [2:0] TARGET_SMALL = 3'd2;

    localparam logic [FreqW-1:0] FREQ_A_RESET   = 26'd1000;
    localparam logic [FreqW-1:0] FREQ_B_RESET   = 26'd2000;
    localparam logic [TimeW-1:0] INTERVAL_RESET = 32'd100;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [3:0]       step_slot;
        logic             step_is_large;
        logic [TimeW-1:0] step_delay_ms;
        logic [4:0]       step_total;
    } t_item;

    typedef struct packed {
        logic             drive_on;
        logic             freq_select;
        logic [FreqW-1:0] freq_hz;
        logic [3:0]       step_number;
        logic             running;
    } t_result;

endpackage

// ===== rtl/core/two_frequency_pwm_step_sequencer.sv =====
// Two-frequency PWM step sequencer.
// Input channel (i_valid/o_ready) carries one command per transfer: a one
// millisecond tick, a step-table load, a start with a step count, or a stop.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_data) set frequency A,
// frequency B and the switch interval; write them only while idle.
// Output channel (o_valid/i_ready) returns exactly one result per command:
// drive enable, selected frequency and its value, step number, running.
// A command accepted at the input is registered there, processed by the core
// when the result register is free or draining, and its result registered.
// Throughput: one command per cycle while i_ready stays high; the state update
// is combinational logic between the input and result
// registers. The step table read is registered and addressed by the next-state step.
// Reset: idle, drive off, frequency A selected, step 0, configuration back
// to 1000 Hz, 2000 Hz and 100 ms. Step table contents are not cleared.
// Stall: when i_ready is low the result holds; one more command may wait in
// the input register, after which o_ready drops until the result drains.
module two_frequency_pwm_step_sequencer #(
    parameter int MAX_STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_cmd,
    input  logic [3:0]                     i_step_slot,
    input  logic                           i_step_is_large,
    input  logic [tfps_pkg::TimeW-1:0]     i_step_delay_ms,
    input  logic [4:0]                     i_step_total,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_addr,
    input  logic [tfps_pkg::CfgW-1:0]      i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_drive_on,
    output logic                           o_freq_select,
    output logic [tfps_pkg::FreqW-1:0]     o_freq_hz,
    output logic [3:0]                     o_step_number,
    output logic                           o_running
);

    tfps_pkg::t_item   in_item;
    tfps_pkg::t_item   q_item;
    tfps_pkg::t_result core_result;
    tfps_pkg::t_result r_out;
    logic              q_valid;
    logic              take;
    logic              r_out_valid;

    assign in_item.cmd           = i_cmd;
    assign in_item.step_slot     = i_step_slot;
    assign in_item.step_is_large = i_step_is_large;
    assign in_item.step_delay_ms = i_step_delay_ms;
    assign in_item.step_total    = i_step_total;

    // process a command whenever the result register is free or draining
    assign take = q_valid && (!r_out_valid || i_ready);

    tfps_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    tfps_core #(
        .MAX_STEPS (MAX_STEPS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (take),
        .i_item     (q_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_result   (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_drive_on    = r_out.drive_on;
    assign o_freq_select = r_out.freq_select;
    assign o_freq_hz     = r_out.freq_hz;
    assign o_step_number = r_out.step_number;
    assign o_running     = r_out.running;

endmodule

// ===== rtl/core/tfps_in_reg.sv =====
module tfps_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tfps_pkg::t_item     i_item,
    input  logic                i_take,
    output logic                o_valid,
    output tfps_pkg::t_item     o_item
);

    logic            r_valid;
    tfps_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // hold the payload until the core takes it
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/core/tfps_core.sv =====
module tfps_core #(
    parameter int MAX_STEPS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  tfps_pkg::t_item              i_item,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_addr,
    input  logic [tfps_pkg::CfgW-1:0]    i_cfg_data,
    output tfps_pkg::t_result            o_result
);

    localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int TW = tfps_pkg::TimeW;
    localparam int FW = tfps_pkg::FreqW;

    logic [FW-1:0] r_freq_a;
    logic [FW-1:0] r_freq_b;
    logic [TW-1:0] r_interval;

    logic [1:0]    r_mode,    n_mode;
    logic [SW-1:0] r_cur,     n_cur;
    logic [1:0]    r_toggle,  n_toggle;
    logic [TW-1:0] r_elapsed, n_elapsed;
    logic [CW-1:0] r_steps,   n_steps;
    logic          r_drive,   n_drive;
    logic          r_sel,     n_sel;

    logic          kind_mem  [MAX_STEPS];
    logic [TW-1:0] delay_mem [MAX_STEPS];
    logic          r_rd_kind;
    logic [TW-1:0] r_rd_delay;

    logic          load_we;
    logic [SW-1:0] load_idx;
    logic [TW-1:0] tick_cnt;
    logic [2:0]    next_toggle;
    logic [2:0]    target;
    logic [SW:0]   next_step;

    assign load_idx    = SW'(i_item.step_slot);
    assign tick_cnt    = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign next_toggle = {1'b0, r_toggle} + 3'd1;
    assign target      = r_rd_kind ? tfps_pkg::TARGET_LARGE : tfps_pkg::TARGET_SMALL;
    assign next_step   = {1'b0, r_cur} + 1'b1;

    always_comb begin
        n_mode    = r_mode;
        n_cur     = r_cur;
        n_toggle  = r_toggle;
        n_elapsed = r_elapsed;
        n_steps   = r_steps;
        n_drive   = r_drive;
        n_sel     = r_sel;
        load_we   = 1'b0;
        if (i_fire) begin
            case (i_item.cmd)
                tfps_pkg::CMD_TICK: begin
                    if (r_mode == tfps_pkg::MODE_RUN) begin
                        n_elapsed = tick_cnt;
                        if (tick_cnt >= r_interval) begin
                            n_elapsed = '0;
                            if (next_toggle >= target) begin
                                n_drive = 1'b0;
                                n_mode  = tfps_pkg::MODE_WAIT;
                            end else begin
                                n_toggle = next_toggle[1:0];
                                n_sel    = next_toggle[0];
                            end
                        end
                    end else if (r_mode == tfps_pkg::MODE_WAIT) begin
                        n_elapsed = tick_cnt;
                        if (tick_cnt >= r_rd_delay) begin
                            if (int'(next_step) >= int'(r_steps)) begin
                                n_mode  = tfps_pkg::MODE_IDLE;
                                n_drive = 1'b0;
                            end else begin
                                // advance to the next step, starting on A
                                n_cur     = next_step[SW-1:0];
                                n_toggle  = '0;
                                n_elapsed = '0;
                                n_drive   = 1'b1;
                                n_sel     = 1'b0;
                                n_mode    = tfps_pkg::MODE_RUN;
                            end
                        end
                    end
                end
                tfps_pkg::CMD_LOAD: begin
                    load_we = (r_mode == tfps_pkg::MODE_IDLE) &&
                              (int'(i_item.step_slot) < MAX_STEPS);
                end
                tfps_pkg::CMD_START: begin
                    if (i_item.step_total != '0) begin
                        n_steps   = (int'(i_item.step_total) > MAX_STEPS) ?
                                    CW'(MAX_STEPS) : CW'(i_item.step_total);
                        n_cur     = '0;
                        n_toggle  = '0;
                        n_elapsed = '0;
                        n_drive   = 1'b1;
                        n_sel     = 1'b0;
                        n_mode    = tfps_pkg::MODE_RUN;
                    end
                end
                tfps_pkg::CMD_STOP: begin
                    n_mode  = tfps_pkg::MODE_IDLE;
                    n_drive = 1'b0;
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    always_comb begin
        o_result.drive_on    = n_drive;
        o_result.freq_select = n_sel;
        o_result.freq_hz     = n_sel ? r_freq_b : r_freq_a;
        o_result.step_number = 4'(n_cur);
        o_result.running     = (n_mode != tfps_pkg::MODE_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= tfps_pkg::MODE_IDLE;
            r_cur     <= '0;
            r_toggle  <= '0;
            r_elapsed <= '0;
            r_steps   <= '0;
            r_drive   <= 1'b0;
            r_sel     <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_cur     <= n_cur;
            r_toggle  <= n_toggle;
            r_elapsed <= n_elapsed;
            r_steps   <= n_steps;
            r_drive   <= n_drive;
            r_sel     <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_a   <= tfps_pkg::FREQ_A_RESET;
            r_freq_b   <= tfps_pkg::FREQ_B_RESET;
            r_interval <= tfps_pkg::INTERVAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tfps_pkg::REG_FREQ_A:   r_freq_a   <= i_cfg_data[FW-1:0];
                tfps_pkg::REG_FREQ_B:   r_freq_b   <= i_cfg_data[FW-1:0];
                tfps_pkg::REG_INTERVAL: r_interval <= i_cfg_data[TW-1:0];
                default: begin
                    r_interval <= r_interval;
                end
            endcase
        end
    end

    // step table; read port follows the step that will be current next cycle
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            kind_mem[load_idx]  <= i_item.step_is_large;
            delay_mem[load_idx] <= i_item.step_delay_ms;
        end
        r_rd_kind  <= kind_mem[n_cur];
        r_rd_delay <= delay_mem[n_cur];
    end

endmodule

// ===== tb/two_frequency_pwm_step_sequencer_tb.sv =====
`timescale 1ns / 1ps

module two_frequency_pwm_step_sequencer_tb;

    localparam int unsigned STEP_SLOTS   = 16;
    localparam int unsigned PHASE_ITEMS  = 315;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam logic [tfps_pkg::CfgW-1:0] FREQ_MAX = 32'd40000000;

    localparam tfps_pkg::t_result RESET_STATUS = '{drive_on: 1'b0, freq_select: 1'b0,
                                                   freq_hz: tfps_pkg::FREQ_A_RESET,
                                                   step_number: 4'd0, running: 1'b0};
    localparam tfps_pkg::t_result FAST_START = '{drive_on: 1'b1, freq_select: 1'b0,
                                                 freq_hz: 26'd40000000, step_number: 4'd0,
                                                 running: 1'b1};

    typedef enum logic {ROW_CMD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        tfps_pkg::t_item           item;
        logic [tfps_pkg::CfgW-1:0] cfg_a;
        logic [tfps_pkg::CfgW-1:0] cfg_b;
        logic [tfps_pkg::CfgW-1:0] cfg_interval;
        logic                      typed;
        tfps_pkg::t_result         status;
    } t_script_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [1:0]                 i_cmd = tfps_pkg::CMD_TICK;
    logic [3:0]                 i_step_slot = '0;
    logic                       i_step_is_large = 1'b0;
    logic [tfps_pkg::TimeW-1:0] i_step_delay_ms = '0;
    logic [4:0]                 i_step_total = '0;
    logic                       i_cfg_we = 1'b0;
    logic [1:0]                 i_cfg_addr = tfps_pkg::REG_FREQ_A;
    logic [tfps_pkg::CfgW-1:0]  i_cfg_data = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic                       o_drive_on;
    logic                       o_freq_select;
    logic [tfps_pkg::FreqW-1:0] o_freq_hz;
    logic [3:0]                 o_step_number;
    logic                       o_running;

    // sequencer mirror
    logic [1:0]                 seq_mode = tfps_pkg::MODE_IDLE;
    logic [4:0]                 cur_step = '0;
    logic [2:0]                 toggles = '0;
    logic                       cur_large = 1'b0;
    logic [tfps_pkg::TimeW-1:0] elapsed = '0;
    logic [4:0]                 run_len = '0;
    logic                       drive = 1'b0;
    logic                       sel_b = 1'b0;
    logic                       kind_tbl [STEP_SLOTS];
    logic [tfps_pkg::TimeW-1:0] delay_tbl [STEP_SLOTS];
    logic [STEP_SLOTS-1:0]      slot_loaded = '0;
    logic [tfps_pkg::FreqW-1:0] freq_a = tfps_pkg::FREQ_A_RESET;
    logic [tfps_pkg::FreqW-1:0] freq_b = tfps_pkg::FREQ_B_RESET;
    logic [tfps_pkg::TimeW-1:0] interval = tfps_pkg::INTERVAL_RESET;

    tfps_pkg::t_result expected_status_q [$];
    t_script_row       script_q [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned sent_items = 0;
    int unsigned applied_items = 0;
    int unsigned tick_count = 0;
    int unsigned load_count = 0;
    int unsigned start_count = 0;
    int unsigned stop_count = 0;
    int unsigned finished_runs = 0;
    int unsigned statuses_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;

    two_frequency_pwm_step_sequencer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_step_slot     (i_step_slot),
        .i_step_is_large (i_step_is_large),
        .i_step_delay_ms (i_step_delay_ms),
        .i_step_total    (i_step_total),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_drive_on      (o_drive_on),
        .o_freq_select   (o_freq_select),
        .o_freq_hz       (o_freq_hz),
        .o_step_number   (o_step_number),
        .o_running       (o_running)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void enter_step(input logic [4:0] idx);
        cur_step  = idx;
        cur_large = kind_tbl[idx[3:0]];
        toggles   = '0;
        elapsed   = '0;
        drive     = 1'b1;
        sel_b     = 1'b0;
        seq_mode  = tfps_pkg::MODE_RUN;
    endfunction

    function automatic void advance_sequencer(input tfps_pkg::t_item it,
                                              output tfps_pkg::t_result status,
                                              output logic effective);
        logic [2:0] nxt;
        logic [2:0] goal;
        effective = 1'b1;
        case (it.cmd)
            tfps_pkg::CMD_TICK: begin
                if (seq_mode == tfps_pkg::MODE_IDLE) begin
                    effective = 1'b0;
                end else begin
                    tick_count++;
                    if (elapsed != '1) elapsed = elapsed + 1'b1;
                    if (seq_mode == tfps_pkg::MODE_RUN) begin
                        if (elapsed >= interval) begin
                            nxt = toggles + 3'd1;
                            goal = cur_large ? tfps_pkg::TARGET_LARGE : tfps_pkg::TARGET_SMALL;
                            elapsed = '0;
                            // the change that reaches the target turns the drive off
                            if (nxt >= goal) begin
                                drive = 1'b0;
                                seq_mode = tfps_pkg::MODE_WAIT;
                            end else begin
                                toggles = nxt;
                                sel_b = nxt[0];
                            end
                        end
                    end else if (elapsed >= delay_tbl[cur_step[3:0]]) begin
                        if (cur_step + 5'd1 >= run_len) begin
                            seq_mode = tfps_pkg::MODE_IDLE;
                            drive = 1'b0;
                            finished_runs++;
                        end else begin
                            enter_step(cur_step + 5'd1);
                        end
                    end
                end
            end
            tfps_pkg::CMD_LOAD: begin
                if (seq_mode == tfps_pkg::MODE_IDLE) begin
                    kind_tbl[it.step_slot] = it.step_is_large;
                    delay_tbl[it.step_slot] = it.step_delay_ms;
                    slot_loaded[it.step_slot] = 1'b1;
                    load_count++;
                end else begin
                    effective = 1'b0;
                end
            end
            tfps_pkg::CMD_START: begin
                if (it.step_total != '0) begin
                    run_len = (it.step_total > STEP_SLOTS) ? 5'(STEP_SLOTS) : it.step_total;
                    enter_step('0);
                    start_count++;
                end else begin
                    effective = 1'b0;
                end
            end
            tfps_pkg::CMD_STOP: begin
                seq_mode = tfps_pkg::MODE_IDLE;
                drive = 1'b0;
                stop_count++;
            end
            default: ;
        endcase
        status.drive_on    = drive;
        status.freq_select = sel_b;
        status.freq_hz     = sel_b ? freq_b : freq_a;
        status.step_number = cur_step[3:0];
        status.running     = (seq_mode != tfps_pkg::MODE_IDLE);
    endfunction

    function automatic int unsigned loaded_prefix();
        int unsigned n;
        n = 0;
        while (n < STEP_SLOTS && slot_loaded[n]) n++;
        return n;
    endfunction

    // never run past the loaded part of the table
    function automatic logic [4:0] pick_total();
        int unsigned have;
        have = loaded_prefix();
        if (have < STEP_SLOTS) return 5'($urandom_range(have));
        case ($urandom_range(9))
            0: return '0;
            1: return 5'($urandom_range(31, 17));
            2: return 5'($urandom_range(16, 5));
            default: return 5'($urandom_range(4, 1));
        endcase
    endfunction

    function automatic tfps_pkg::t_item random_item(input logic [1:0] cmd);
        tfps_pkg::t_item it;
        it.cmd           = cmd;
        it.step_slot     = 4'($urandom_range(15));
        it.step_is_large = 1'($urandom_range(1));
        it.step_delay_ms = $urandom();
        it.step_total    = 5'($urandom_range(31));
        return it;
    endfunction

    function automatic t_script_row cmd_row(input logic [1:0] cmd, input logic [3:0] slot,
                                            input logic is_large,
                                            input logic [tfps_pkg::TimeW-1:0] delay,
                                            input logic [4:0] total, input logic typed,
                                            input tfps_pkg::t_result status);
        t_script_row row;
        row.kind               = ROW_CMD;
        row.item.cmd           = cmd;
        row.item.step_slot     = slot;
        row.item.step_is_large = is_large;
        row.item.step_delay_ms = delay;
        row.item.step_total    = total;
        row.cfg_a              = '0;
        row.cfg_b              = '0;
        row.cfg_interval       = '0;
        row.typed              = typed;
        row.status             = status;
        return row;
    endfunction

    function automatic t_script_row cfg_row(input logic [tfps_pkg::CfgW-1:0] fa,
                                            input logic [tfps_pkg::CfgW-1:0] fb,
                                            input logic [tfps_pkg::CfgW-1:0] ival);
        t_script_row row;
        row = cmd_row(tfps_pkg::CMD_TICK, '0, 1'b0, '0, '0, 1'b0, '0);
        row.kind         = ROW_CFG;
        row.cfg_a        = fa;
        row.cfg_b        = fb;
        row.cfg_interval = ival;
        return row;
    endfunction

    task automatic send_cmd(input tfps_pkg::t_item it, input logic typed,
                            input tfps_pkg::t_result status);
        tfps_pkg::t_result predicted;
        logic              effective;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cmd           <= it.cmd;
        i_step_slot     <= it.step_slot;
        i_step_is_large <= it.step_is_large;
        i_step_delay_ms <= it.step_delay_ms;
        i_step_total    <= it.step_total;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        advance_sequencer(it, predicted, effective);
        expected_status_q.push_back(typed ? status : predicted);
        sent_items++;
        if (effective) applied_items++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [tfps_pkg::CfgW-1:0] fa,
                                input logic [tfps_pkg::CfgW-1:0] fb,
                                input logic [tfps_pkg::CfgW-1:0] ival);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= tfps_pkg::REG_FREQ_A;
        i_cfg_data <= fa;
        @(posedge i_clk);
        i_cfg_addr <= tfps_pkg::REG_FREQ_B;
        i_cfg_data <= fb;
        @(posedge i_clk);
        i_cfg_addr <= tfps_pkg::REG_INTERVAL;
        i_cfg_data <= ival;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        freq_a   = fa[tfps_pkg::FreqW-1:0];
        freq_b   = fb[tfps_pkg::FreqW-1:0];
        interval = ival;
    endtask

    task automatic run_sequences(input int unsigned quota);
        int unsigned     stop_at;
        int unsigned     have;
        tfps_pkg::t_item it;
        stop_at = sent_items + quota;
        while (sent_items < stop_at) begin
            if (seq_mode != tfps_pkg::MODE_IDLE && $urandom_range(1) == 0)
                send_cmd(random_item(tfps_pkg::CMD_STOP), 1'b0, '0);
            repeat ($urandom_range(3)) begin
                have = loaded_prefix();
                it = random_item(tfps_pkg::CMD_LOAD);
                // grow the loaded part of the table from slot zero upward
                if ($urandom_range(9) < 7)
                    it.step_slot = 4'($urandom_range(have < STEP_SLOTS ? have : STEP_SLOTS - 1));
                case ($urandom_range(19))
                    0: it.step_delay_ms = '1;
                    1: it.step_delay_ms = $urandom();
                    default: it.step_delay_ms = tfps_pkg::TimeW'($urandom_range(4));
                endcase
                send_cmd(it, 1'b0, '0);
            end
            it = random_item(tfps_pkg::CMD_START);
            it.step_total = pick_total();
            send_cmd(it, 1'b0, '0);
            repeat ($urandom_range(60, 1)) begin
                if ($urandom_range(24) == 0) begin
                    it = random_item(2'($urandom_range(3)));
                    if (it.cmd == tfps_pkg::CMD_START) it.step_total = pick_total();
                end else begin
                    it = random_item(tfps_pkg::CMD_TICK);
                end
                send_cmd(it, 1'b0, '0);
            end
            if ($urandom_range(1) == 0) send_cmd(random_item(tfps_pkg::CMD_STOP), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input logic squeeze, input logic [tfps_pkg::CfgW-1:0] fa,
                             input logic [tfps_pkg::CfgW-1:0] fb,
                             input logic [tfps_pkg::CfgW-1:0] ival);
        settle();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        program_regs(fa, fb, ival);
        run_sequences(PHASE_ITEMS / 2);
        if (squeeze) begin
            // hold the output while commands keep coming, then drain fully
            hold_requests++;
            run_sequences(40);
            settle();
        end
        run_sequences(PHASE_ITEMS - PHASE_ITEMS / 2);
        send_cmd(random_item(tfps_pkg::CMD_STOP), 1'b0, '0);
    endtask

    initial begin : result_side
        int unsigned holds_done;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_status
        tfps_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_status_q.size() == 0) begin
                $error("status transfer with nothing expected");
                mismatch_count++;
            end else begin
                want = expected_status_q.pop_front();
                statuses_checked++;
                if (o_drive_on !== want.drive_on) begin
                    $error("drive_on: expected %0d, got %0d", want.drive_on, o_drive_on);
                    mismatch_count++;
                end
                if (o_freq_select !== want.freq_select) begin
                    $error("freq_select: expected %0d, got %0d", want.freq_select,
                           o_freq_select);
                    mismatch_count++;
                end
                if (o_freq_hz !== want.freq_hz) begin
                    $error("freq_hz: expected %0d, got %0d", want.freq_hz, o_freq_hz);
                    mismatch_count++;
                end
                if (o_step_number !== want.step_number) begin
                    $error("step_number: expected %0d, got %0d", want.step_number,
                           o_step_number);
                    mismatch_count++;
                end
                if (o_running !== want.running) begin
                    $error("running: expected %0d, got %0d", want.running, o_running);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("two_frequency_pwm_step_sequencer_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle block with reset settings: nothing may move
        script_q.push_back(cmd_row(tfps_pkg::CMD_TICK, 4'd0, 1'b0, 32'd0, 5'd0, 1'b1,
                                   RESET_STATUS));
        script_q.push_back(cmd_row(tfps_pkg::CMD_START, 4'd0, 1'b0, 32'd0, 5'd0, 1'b1,
                                   RESET_STATUS));
        script_q.push_back(cmd_row(tfps_pkg::CMD_STOP, 4'd0, 1'b0, 32'd0, 5'd0, 1'b1,
                                   RESET_STATUS));
        script_q.push_back(cmd_row(tfps_pkg::CMD_LOAD, 4'd0, 1'b1, 32'd0, 5'd0, 1'b1,
                                   RESET_STATUS));
        script_q.push_back(cmd_row(tfps_pkg::CMD_LOAD, 4'd15, 1'b0, '1, 5'd31, 1'b1,
                                   RESET_STATUS));
        script_q.push_back(cmd_row(tfps_pkg::CMD_LOAD, 4'd1, 1'b0, 32'd1, 5'd0, 1'b0, '0));
        // zero interval: every tick in a running step makes a change
        script_q.push_back(cfg_row(FREQ_MAX, 32'd1, 32'd0));
        script_q.push_back(cmd_row(tfps_pkg::CMD_START, 4'd0, 1'b0, 32'd0, 5'd2, 1'b1,
                                   FAST_START));
        script_q.push_back(cmd_row(tfps_pkg::CMD_LOAD, 4'd2, 1'b1, 32'd3, 5'd0, 1'b0, '0));
        repeat (8)
            script_q.push_back(cmd_row(tfps_pkg::CMD_TICK, 4'd0, 1'b0, 32'd0, 5'd0, 1'b0, '0));
        script_q.push_back(cmd_row(tfps_pkg::CMD_START, 4'd0, 1'b0, 32'd0, 5'd2, 1'b0, '0));
        script_q.push_back(cmd_row(tfps_pkg::CMD_TICK, 4'd0, 1'b0, 32'd0, 5'd0, 1'b0, '0));
        script_q.push_back(cmd_row(tfps_pkg::CMD_START, 4'd0, 1'b0, 32'd0, 5'd2, 1'b0, '0));
        script_q.push_back(cmd_row(tfps_pkg::CMD_STOP, 4'd0, 1'b0, 32'd0, 5'd0, 1'b0, '0));
        script_q.push_back(cmd_row(tfps_pkg::CMD_TICK, 4'd0, 1'b0, 32'd0, 5'd0, 1'b0, '0));
        script_q.push_back(cmd_row(tfps_pkg::CMD_LOAD, 4'd2, 1'b1, 32'd3, 5'd0, 1'b0, '0));
        script_q.push_back(cfg_row(FREQ_MAX, 32'd1, '1));
        script_q.push_back(cmd_row(tfps_pkg::CMD_START, 4'd0, 1'b0, 32'd0, 5'd1, 1'b1,
                                   FAST_START));
        script_q.push_back(cmd_row(tfps_pkg::CMD_TICK, 4'd0, 1'b0, 32'd0, 5'd0, 1'b0, '0));
        script_q.push_back(cmd_row(tfps_pkg::CMD_STOP, 4'd0, 1'b0, 32'd0, 5'd0, 1'b0, '0));

        foreach (script_q[k]) begin
            if (script_q[k].kind == ROW_CFG) begin
                settle();
                program_regs(script_q[k].cfg_a, script_q[k].cfg_b, script_q[k].cfg_interval);
            end else begin
                send_cmd(script_q[k].item, script_q[k].typed, script_q[k].status);
            end
        end

        run_phase(0, 0, 1'b0, 32'd1, FREQ_MAX, 32'd0);
        run_phase(80, 0, 1'b0, $urandom_range(40000000, 1), $urandom_range(40000000, 1),
                  32'd1);
        run_phase(0, 80, 1'b0, $urandom_range(40000000, 1), $urandom_range(40000000, 1),
                  32'd2);
        run_phase(21, 21, 1'b0, FREQ_MAX, 32'd1, 32'd0);
        run_phase(0, 0, 1'b1, $urandom_range(40000000, 1), $urandom_range(40000000, 1),
                  32'd3);
        settle();

        $display("%0d status transfers checked over %0d commands, %0d of them effective",
                 statuses_checked, sent_items, applied_items);
        $display("%0d loads, %0d starts, %0d stops, %0d ticks; %0d step sequences ran out",
                 load_count, start_count, stop_count, tick_count, finished_runs);
        if (mismatch_count == 0 && expected_status_q.size() == 0) begin
            $display("two_frequency_pwm_step_sequencer_tb passed");
        end else begin
            $display("two_frequency_pwm_step_sequencer_tb failed");
        end
        $finish;
    end

endmodule
